>>> rtl/png_scanline_unfilter_macros.svh
// assertion macros for the png scanline unfilter checker
// depends on clk and rst_n being visible where the macros are used
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// property checked outside reset only
`define PSU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked on every edge, reset included
`define PSU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> rtl/psu_pkg.sv
// shared types and constants of the png scanline unfilter
// no dependencies
package psu_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int COLUMN_W    = 12;
    localparam int ROW_W       = 16;
    localparam int WIDTH_CFG_W = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PIXEL_W     = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_ALPHA    = 2'd2;

    // largest legal filter type code
    localparam logic [SAMPLE_W-1:0] FILTER_TYPE_MAX = 8'd4;

    // alpha value for rgb images
    localparam logic [SAMPLE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    // one classified sample word, front to back
    typedef struct packed {
        logic [SAMPLE_W-1:0] data_byte;
        logic [1:0]          lane;
        logic                pixel_last;
        logic                rgba;
        filter_t             filt;
        logic                bad;
        logic [ROW_W-1:0]    row;
        logic                eor;
        logic                eoi;
    } sample_cmd_t;

endpackage

>>> rtl/psu_stream_if.sv
// valid/ready stream interfaces for byte input and pixel output words
// depends on psu_pkg for field widths

// inflated byte stream
interface psu_byte_if;
    logic                          valid;
    logic                          ready;
    logic [psu_pkg::SAMPLE_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// reconstructed pixel stream
interface psu_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [psu_pkg::SAMPLE_W-1:0]  red;
    logic [psu_pkg::SAMPLE_W-1:0]  green;
    logic [psu_pkg::SAMPLE_W-1:0]  blue;
    logic [psu_pkg::SAMPLE_W-1:0]  alpha;
    logic [psu_pkg::COLUMN_W-1:0]  column;
    logic [psu_pkg::ROW_W-1:0]     row_index;
    logic                          end_of_row;
    logic                          end_of_image;
    logic                          bad_filter;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output column, output row_index, output end_of_row,
                    output end_of_image, output bad_filter, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input column, input row_index, input end_of_row,
                    input end_of_image, input bad_filter, output ready);
endinterface

>>> rtl/psu_front.sv
// front end: config registers, byte classification and row/column tracking
// depends on psu_pkg and psu_byte_if
module psu_front #(
    parameter int CW        = 12,
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [psu_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]      cfg_data,
    psu_byte_if.sink                            byte_stream,
    input  logic                                q_full,
    output logic                                push,
    output psu_pkg::sample_cmd_t                push_cmd,
    output logic [CW-1:0]                       push_col
);

    localparam int EW = (CW + 1 > psu_pkg::WIDTH_CFG_W) ? CW + 1 : psu_pkg::WIDTH_CFG_W;
    localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);

    logic [psu_pkg::WIDTH_CFG_W-1:0] width_cfg_reg;
    logic [psu_pkg::ROW_W-1:0]       height_cfg_reg;
    logic                            alpha_cfg_reg;

    logic                      awaiting_reg, awaiting_next;
    logic [1:0]                bip_reg, bip_next;
    logic [CW-1:0]             col_reg, col_next;
    logic [psu_pkg::ROW_W-1:0] row_reg, row_next;
    psu_pkg::filter_t          filt_reg, filt_next;
    logic                      bad_reg, bad_next;

    logic                      accept;
    logic [EW-1:0]             width_ext;
    logic [EW-1:0]             eff_width;
    logic [psu_pkg::ROW_W:0]   eff_height;
    logic                      pixel_last;
    logic                      eor;
    logic                      eoi;
    logic                      filt_bad;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= psu_pkg::WIDTH_CFG_W'(1);
            height_cfg_reg <= psu_pkg::ROW_W'(1);
            alpha_cfg_reg  <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                psu_pkg::CFG_IMAGE_WIDTH:
                    width_cfg_reg <= cfg_data[psu_pkg::WIDTH_CFG_W-1:0];
                psu_pkg::CFG_IMAGE_HEIGHT:
                    height_cfg_reg <= cfg_data[psu_pkg::ROW_W-1:0];
                psu_pkg::CFG_HAS_ALPHA:
                    alpha_cfg_reg <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    assign byte_stream.ready = !q_full;
    assign accept = byte_stream.valid && !q_full;

    // effective image size
    always_comb
    begin
        width_ext = EW'(width_cfg_reg);
        if (width_ext == '0)
            eff_width = EW'(1);
        else if (width_ext > MAX_W)
            eff_width = MAX_W;
        else
            eff_width = width_ext;
        if (height_cfg_reg == '0)
            eff_height = (psu_pkg::ROW_W + 1)'(1);
        else
            eff_height = {1'b0, height_cfg_reg};
    end

    // pixel and row boundaries of the current byte
    assign pixel_last = (bip_reg == 2'd3) || (bip_reg == 2'd2 && !alpha_cfg_reg);
    assign eor        = (EW'(col_reg) + EW'(1)) >= eff_width;
    assign eoi        = eor && (({1'b0, row_reg} + (psu_pkg::ROW_W + 1)'(1)) >= eff_height);
    assign filt_bad   = byte_stream.data_byte > psu_pkg::FILTER_TYPE_MAX;

    // sample word toward the back end
    always_comb
    begin
        push                = accept && !awaiting_reg;
        push_col            = col_reg;
        push_cmd.data_byte  = byte_stream.data_byte;
        push_cmd.lane       = bip_reg;
        push_cmd.pixel_last = pixel_last;
        push_cmd.rgba       = alpha_cfg_reg;
        push_cmd.filt       = filt_reg;
        push_cmd.bad        = bad_reg;
        push_cmd.row        = row_reg;
        push_cmd.eor        = eor;
        push_cmd.eoi        = eoi;
    end

    // stream position update
    always_comb
    begin
        awaiting_next = awaiting_reg;
        bip_next      = bip_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        filt_next     = filt_reg;
        bad_next      = bad_reg;
        if (accept)
        begin
            if (awaiting_reg)
            begin
                bad_next      = filt_bad;
                filt_next     = filt_bad ? psu_pkg::FILT_NONE
                                         : psu_pkg::filter_t'(byte_stream.data_byte[2:0]);
                awaiting_next = 1'b0;
                bip_next      = 2'd0;
                col_next      = '0;
            end
            else if (pixel_last)
            begin
                bip_next = 2'd0;
                if (eor)
                begin
                    awaiting_next = 1'b1;
                    col_next      = '0;
                    row_next      = eoi ? '0 : row_reg + psu_pkg::ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            else
            begin
                bip_next = bip_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b1;
            bip_reg      <= 2'd0;
            col_reg      <= '0;
            row_reg      <= '0;
            filt_reg     <= psu_pkg::FILT_NONE;
            bad_reg      <= 1'b0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            bip_reg      <= bip_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            filt_reg     <= filt_next;
            bad_reg      <= bad_next;
        end
    end

endmodule

>>> rtl/psu_queue.sv
// short queue of classified sample words between front and back end
// depends on psu_pkg
module psu_queue #(
    parameter int DEPTH = 4,
    parameter int CW    = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  psu_pkg::sample_cmd_t  push_cmd,
    input  logic [CW-1:0]         push_col,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output psu_pkg::sample_cmd_t  head_cmd,
    output logic [CW-1:0]         head_col
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    psu_pkg::sample_cmd_t cmd_reg [DEPTH];
    logic [CW-1:0]        col_reg [DEPTH];
    logic [PW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]        count_reg, count_next;

    assign full       = (count_reg == NW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = cmd_reg[rd_ptr_reg];
    assign head_col   = col_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_reg[wr_ptr_reg] <= push_cmd;
            col_reg[wr_ptr_reg] <= push_col;
        end
    end

endmodule

>>> rtl/psu_back.sv
// back end: per-channel filter reconstruction, line buffer and output register
// depends on psu_pkg and psu_pixel_if
module psu_back #(
    parameter int CW = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  psu_pkg::sample_cmd_t  head_cmd,
    input  logic [CW-1:0]         head_col,
    output logic                  pop,
    psu_pixel_if.source           pixel_stream
);

    localparam int DEPTH = 2 ** CW;

    // previous row line buffer
    logic [psu_pkg::PIXEL_W-1:0] line_mem [DEPTH];
    logic [psu_pkg::PIXEL_W-1:0] above_rd_reg;

    logic [psu_pkg::PIXEL_W-1:0] partial_reg;
    logic [psu_pkg::PIXEL_W-1:0] left_reg;
    logic [psu_pkg::PIXEL_W-1:0] upleft_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [psu_pkg::PIXEL_W-1:0] out_pix_reg;
    logic [CW-1:0]               out_col_reg;
    logic [psu_pkg::ROW_W-1:0]   out_row_reg;
    logic                        out_eor_reg;
    logic                        out_eoi_reg;
    logic                        out_bad_reg;

    logic                        finish;
    logic [4:0]                  lane_sh;
    logic                        first_col;
    logic [psu_pkg::PIXEL_W-1:0] above_px;
    logic [7:0]                  a_smp, b_smp, c_smp;
    logic [8:0]                  ab_sum;
    logic [7:0]                  pred;
    logic [7:0]                  recon;
    logic [psu_pkg::PIXEL_W-1:0] px;
    logic [CW-1:0]               next_col;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a,
                                              input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [9:0] pa;
        logic signed [9:0] pb;
        logic signed [9:0] pc;
        pa = $signed({2'b00, b}) - $signed({2'b00, c});
        pb = $signed({2'b00, a}) - $signed({2'b00, c});
        pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        if (pa < 0)
            pa = -pa;
        if (pb < 0)
            pb = -pb;
        if (pc < 0)
            pc = -pc;
        if (pa <= pb && pa <= pc)
            paeth_pick = a;
        else if (pb <= pc)
            paeth_pick = b;
        else
            paeth_pick = c;
    endfunction

    // take a word unless it completes a pixel and the output slot is held
    assign pop    = head_valid && (!head_cmd.pixel_last || !out_valid_reg || pixel_stream.ready);
    assign finish = pop && head_cmd.pixel_last;

    // neighbor samples of the current channel
    always_comb
    begin
        lane_sh   = {head_cmd.lane, 3'b000};
        first_col = (head_col == '0);
        above_px  = (head_cmd.row != '0) ? above_rd_reg : '0;
        a_smp     = first_col ? 8'd0 : left_reg[lane_sh +: 8];
        b_smp     = above_px[lane_sh +: 8];
        c_smp     = first_col ? 8'd0 : upleft_reg[lane_sh +: 8];
        ab_sum    = {1'b0, a_smp} + {1'b0, b_smp};
    end

    // predictor select
    always_comb
    begin
        unique case (head_cmd.filt)
            psu_pkg::FILT_SUB:   pred = a_smp;
            psu_pkg::FILT_UP:    pred = b_smp;
            psu_pkg::FILT_AVG:   pred = ab_sum[8:1];
            psu_pkg::FILT_PAETH: pred = paeth_pick(a_smp, b_smp, c_smp);
            default:             pred = 8'd0;
        endcase
    end

    // merge the reconstructed sample into the pixel
    always_comb
    begin
        recon            = head_cmd.data_byte + pred;
        px               = partial_reg;
        px[lane_sh +: 8] = recon;
        if (!head_cmd.rgba)
            px[31:24] = psu_pkg::ALPHA_OPAQUE;
        next_col = head_cmd.eor ? '0 : head_col + CW'(1);
    end

    // pixel assembly and neighbor registers
    always_ff @(posedge clk)
    begin
        if (pop)
            partial_reg <= px;
        if (finish)
        begin
            left_reg   <= px;
            upleft_reg <= above_px;
        end
    end

    // line buffer write, next column prefetch with write bypass
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            line_mem[head_col] <= px;
            if (next_col == head_col)
                above_rd_reg <= px;
            else
                above_rd_reg <= line_mem[next_col];
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
            out_valid_next = 1'b1;
        else if (pixel_stream.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_pix_reg <= px;
            out_col_reg <= head_col;
            out_row_reg <= head_cmd.row;
            out_eor_reg <= head_cmd.eor;
            out_eoi_reg <= head_cmd.eoi;
            out_bad_reg <= head_cmd.bad;
        end
    end

    assign pixel_stream.valid        = out_valid_reg;
    assign pixel_stream.red          = out_pix_reg[7:0];
    assign pixel_stream.green        = out_pix_reg[15:8];
    assign pixel_stream.blue         = out_pix_reg[23:16];
    assign pixel_stream.alpha        = out_pix_reg[31:24];
    assign pixel_stream.column       = psu_pkg::COLUMN_W'(out_col_reg);
    assign pixel_stream.row_index    = out_row_reg;
    assign pixel_stream.end_of_row   = out_eor_reg;
    assign pixel_stream.end_of_image = out_eoi_reg;
    assign pixel_stream.bad_filter   = out_bad_reg;

endmodule

>>> rtl/png_scanline_unfilter.sv
// top level of the png scanline unfilter: front end, queue and back end
// depends on psu_pkg, psu_stream_if, psu_front, psu_queue and psu_back
//
//   channel        dir  handshake     payload
//   byte_stream    in   valid/ready   data_byte
//   pixel_stream   out  valid/ready   red green blue alpha column row_index
//                                     end_of_row end_of_image bad_filter
//   cfg_*          in   cfg_write_en  cfg_index cfg_data
//
// one byte is taken per cycle while the queue is not full; an rgb pixel has 3 bytes,
// rgba 4, plus the filter byte at each row start
// a pixel is loaded into the output register once its last byte has passed the
// queue, without waiting when the queue is empty and the output register is free
// the line buffer is read one pixel ahead through a read port apart from its write port, so the
// left/above samples of a pixel are ready when its first byte reaches the back
// reset clears control state only; the line buffer needs no clearing pass
// a stalled output holds the back end at a pixel's last byte, the front keeps going until the queue fills
module png_scanline_unfilter #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [psu_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_data,
    psu_byte_if.sink                         byte_stream,
    psu_pixel_if.source                      pixel_stream
);

    localparam int CW          = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int QUEUE_DEPTH = 4;

    logic                 push;
    psu_pkg::sample_cmd_t push_cmd;
    logic [CW-1:0]        push_col;
    logic                 q_full;
    logic                 pop;
    logic                 head_valid;
    psu_pkg::sample_cmd_t head_cmd;
    logic [CW-1:0]        head_col;

    // byte classification
    psu_front #(
        .CW        (CW),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_stream  (byte_stream),
        .q_full       (q_full),
        .push         (push),
        .push_cmd     (push_cmd),
        .push_col     (push_col)
    );

    // decoupling queue
    psu_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_col   (push_col),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .head_col   (head_col)
    );

    // reconstruction and output
    psu_back #(
        .CW (CW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .head_col     (head_col),
        .pop          (pop),
        .pixel_stream (pixel_stream)
    );

endmodule

>>> rtl/psu_checker.sv
// port-level checks of the png scanline unfilter, bound to the top level
// depends on psu_pkg and png_scanline_unfilter_macros.svh
`include "png_scanline_unfilter_macros.svh"

module psu_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            pixel_valid,
    input logic                            pixel_ready,
    input logic [psu_pkg::SAMPLE_W-1:0]    red,
    input logic [psu_pkg::SAMPLE_W-1:0]    green,
    input logic [psu_pkg::SAMPLE_W-1:0]    blue,
    input logic [psu_pkg::SAMPLE_W-1:0]    alpha,
    input logic [psu_pkg::COLUMN_W-1:0]    column,
    input logic [psu_pkg::ROW_W-1:0]       row_index,
    input logic                            end_of_row,
    input logic                            end_of_image,
    input logic                            bad_filter
);

    // no word leaves right after reset
    `PSU_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !pixel_valid, "pixel valid after reset")

    // image end always closes a row
    `PSU_ASSERT(a_eoi_is_eor, pixel_valid && end_of_image |-> end_of_row, "image end without row end")

    // a stalled word stays offered
    `PSU_ASSERT(a_valid_hold, pixel_valid && !pixel_ready |=> pixel_valid, "pixel word dropped")

    // a stalled word keeps its payload
    `PSU_ASSERT(a_payload_hold, pixel_valid && !pixel_ready |=> $stable(red) && $stable(green) && $stable(blue) && $stable(alpha) && $stable(column) && $stable(row_index) && $stable(end_of_row) && $stable(end_of_image) && $stable(bad_filter), "pixel payload changed")

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_stream.valid),
    .pixel_ready  (pixel_stream.ready),
    .red          (pixel_stream.red),
    .green        (pixel_stream.green),
    .blue         (pixel_stream.blue),
    .alpha        (pixel_stream.alpha),
    .column       (pixel_stream.column),
    .row_index    (pixel_stream.row_index),
    .end_of_row   (pixel_stream.end_of_row),
    .end_of_image (pixel_stream.end_of_image),
    .bad_filter   (pixel_stream.bad_filter)
);
